FILE: sv/swsm_pkg.sv
// swsm_pkg: shared types and constants of the shifted word set match core
// no dependencies; used by every module of the core by scoped name
package swsm_pkg;

    localparam int MAX_LEN   = 16;
    localparam int MAX_WORDS = 256;
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int CHAR_W    = 8;
    localparam int KEY_W     = 16;
    localparam int SHIFT_W   = 5;
    localparam int WLEN_W    = 5;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(MAX_LEN);

    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [MAX_LEN-1:0][CHAR_W-1:0] word_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] lenm1;
        word_t            word;
    } cmd_t;

endpackage

FILE: sv/swsm_front.sv
// swsm_front: input beat decode, key shift table, word buffer and query shift
// depends on swsm_pkg; pushes completed words as commands into swsm_queue
module swsm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [swsm_pkg::WLEN_W-1:0]   cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    s_tuser,
    input  logic [31:0]                   s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output swsm_pkg::cmd_t                q_cmd
);

    function automatic logic [swsm_pkg::SHIFT_W-1:0] key_mod(
        input logic [swsm_pkg::KEY_W-1:0] k);
        logic [31:0] prod;
        logic [11:0] q;
        logic [15:0] r;
        prod = 32'(k) * 32'd40330;
        q    = prod[31:20];
        r    = k - (16'(q) * 16'd26);
        return r[swsm_pkg::SHIFT_W-1:0];
    endfunction

    function automatic logic [7:0] shift_char(input logic [7:0] c,
                                              input logic [4:0] k);
        logic [8:0]  sum;
        logic [7:0]  x;
        logic [15:0] prod;
        logic [2:0]  q;
        logic [7:0]  r;
        sum  = 9'(c) + 9'(k);
        x    = 8'(sum - 9'd97);
        prod = 16'(x) * 16'd79;
        q    = prod[13:11];
        r    = x - (8'(q) * 8'd26);
        if (sum >= 9'd123) begin
            return 8'd97 + r;
        end else begin
            return sum[7:0];
        end
    endfunction

    logic [swsm_pkg::WLEN_W-1:0]  wlen_reg;
    logic [swsm_pkg::SHIFT_W-1:0] key_reg [swsm_pkg::MAX_LEN];
    swsm_pkg::word_t              buf_reg;
    swsm_pkg::word_t              buf_next;

    logic                         accept;
    logic [1:0]                   op;
    logic [swsm_pkg::POS_W-1:0]   pos;
    logic [7:0]                   ch;
    logic [swsm_pkg::KEY_W-1:0]   key;
    logic [swsm_pkg::POS_W-1:0]   lenm1;
    logic                         is_char;

    assign op  = s_tuser;
    assign pos = s_tdata[3:0];
    assign ch  = s_tdata[11:4];
    assign key = s_tdata[27:12];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_char  = (op == swsm_pkg::OP_STORE) || (op == swsm_pkg::OP_QUERY);

    always_comb begin
        if (wlen_reg == '0) begin
            lenm1 = '0;
        end else if (wlen_reg > swsm_pkg::WLEN_W'(swsm_pkg::MAX_LEN)) begin
            lenm1 = swsm_pkg::POS_W'(swsm_pkg::MAX_LEN - 1);
        end else begin
            lenm1 = swsm_pkg::POS_W'(wlen_reg - 5'd1);
        end
    end

    always_comb begin
        buf_next = buf_reg;
        if (op == swsm_pkg::OP_QUERY) begin
            buf_next[pos] = shift_char(ch, key_reg[pos]);
        end else begin
            buf_next[pos] = ch;
        end
    end

    assign q_push      = accept && is_char && (pos == lenm1);
    assign q_cmd.kind  = (op == swsm_pkg::OP_QUERY) ? swsm_pkg::KIND_QUERY
                                                    : swsm_pkg::KIND_STORE;
    assign q_cmd.lenm1 = lenm1;
    assign q_cmd.word  = buf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= swsm_pkg::WLEN_RESET;
            for (int i = 0; i < swsm_pkg::MAX_LEN; i++) begin
                key_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            if (accept && (op == swsm_pkg::OP_KEY)) begin
                key_reg[pos] <= key_mod(key);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_char) begin
            buf_reg <= buf_next;
        end
    end

endmodule

FILE: sv/swsm_queue.sv
// swsm_queue: two-entry command queue between front and back
// depends on swsm_pkg for the command type
module swsm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  swsm_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output swsm_pkg::cmd_t head
);

    swsm_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");

endmodule

FILE: sv/swsm_back.sv
// swsm_back: word table memory, store append and query scan, result register
// depends on swsm_pkg; takes commands from swsm_queue
module swsm_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  swsm_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [0:0]     m_tuser,
    output logic [7:0]     m_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    swsm_pkg::word_t mem [swsm_pkg::MAX_WORDS];

    logic [1:0]                 state_reg, state_next;
    logic [swsm_pkg::CNT_W-1:0] count_reg, count_next;
    logic [swsm_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                       rd_valid_reg, rd_valid_next;
    logic                       rd_last_reg;
    swsm_pkg::word_t            rd_data_reg;
    logic                       hit_reg, hit_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg, out_kind_next;
    logic                       out_match_reg, out_match_next;
    logic                       out_full_reg, out_full_next;

    logic                       out_free;
    logic                       mem_we;
    logic                       hit;
    logic                       addr_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign addr_last = ({1'b0, addr_reg} == (count_reg - swsm_pkg::CNT_W'(1)));

    always_comb begin
        hit = 1'b1;
        for (int j = 0; j < swsm_pkg::MAX_LEN; j++) begin
            if ((swsm_pkg::POS_W'(j) <= q_head.lenm1) &&
                (rd_data_reg[j] != q_head.word[j])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        rd_valid_next  = 1'b0;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_match_next = out_match_reg;
        out_full_next  = out_full_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (!q_empty && out_free) begin
                    if (q_head.kind == swsm_pkg::KIND_STORE) begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = swsm_pkg::KIND_STORE;
                        out_match_next = 1'b0;
                        if (count_reg >= swsm_pkg::CNT_W'(swsm_pkg::MAX_WORDS)) begin
                            out_full_next = 1'b1;
                        end else begin
                            out_full_next = 1'b0;
                            mem_we        = 1'b1;
                            count_next    = count_reg + swsm_pkg::CNT_W'(1);
                        end
                    end else if (count_reg == '0) begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = swsm_pkg::KIND_QUERY;
                        out_match_next = 1'b0;
                        out_full_next  = 1'b0;
                    end else begin
                        addr_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_valid_next = 1'b1;
                addr_next     = addr_reg + swsm_pkg::ADDR_W'(1);
                if (rd_valid_reg && (hit || rd_last_reg)) begin
                    hit_next      = hit;
                    rd_valid_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = swsm_pkg::KIND_QUERY;
                    out_match_next = hit_reg;
                    out_full_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        hit_reg       <= hit_next;
        out_kind_reg  <= out_kind_next;
        out_match_reg <= out_match_next;
        out_full_reg  <= out_full_next;
        rd_last_reg   <= addr_last;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[swsm_pkg::ADDR_W-1:0]] <= q_head.word;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_full_reg, out_match_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= swsm_pkg::CNT_W'(swsm_pkg::MAX_WORDS))
        else $error("entry count past table size");
    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_full_reg) |->
        (count_reg == swsm_pkg::CNT_W'(swsm_pkg::MAX_WORDS)))
        else $error("drop reported with room in table");
    a_full_only_on_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_full_reg) |-> (out_kind_reg == swsm_pkg::KIND_STORE))
        else $error("full flag on a query result");
    a_scan_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !q_empty)
        else $error("scan running without a command");

endmodule

FILE: sv/shifted_word_set_match_core.sv
// shifted_word_set_match_core: keyed word store with shifted membership queries
// result path with an idle back end: a store result, or a query on an empty table, is
// registered from the queue slot into the result register; other queries first scan the table
// throughput: a query holds the back end through its scan, which stops at a hit or the last entry,
// one table entry compared per cycle; other beats are taken each cycle unless the queue is full
// reset clears key shifts, entry count, queue and result; table contents are kept
module shifted_word_set_match_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [swsm_pkg::WLEN_W-1:0] cfg_wr_data,    // word_length
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [1:0]                  s_tuser,        // opcode
    input  logic [31:0]                 s_tdata,        // position, char_code, key_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [0:0]                  m_tuser,        // result_kind
    output logic [7:0]                  m_tdata         // matched, table_full
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    swsm_pkg::cmd_t q_cmd;
    swsm_pkg::cmd_t q_head;

    swsm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    swsm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    swsm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: bench/word_match_checker.sv
`timescale 1ns / 100ps
// word_match_checker: watches the config port and both streams of the shifted word set
// match core, predicts every result beat and compares it; depends on swsm_pkg
module word_match_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [swsm_pkg::WLEN_W-1:0] cfg_wr_data,    // word_length
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [1:0]                  s_tuser,        // opcode
    input  logic [31:0]                 s_tdata,        // position, char_code, key_value
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [0:0]                  m_tuser,        // result_kind
    input  logic [7:0]                  m_tdata,        // matched, table_full
    output int                          mismatches,
    output int                          outstanding
);

    localparam int ALPHABET = 26;
    localparam int LETTER_A = 97;
    localparam int CHAR_LO  = swsm_pkg::POS_W;
    localparam int KEY_LO   = swsm_pkg::POS_W + swsm_pkg::CHAR_W;

    typedef struct packed {
        logic kind;
        logic matched;
        logic full;
    } answer_t;

    logic [swsm_pkg::WLEN_W-1:0]  word_length;
    logic [swsm_pkg::SHIFT_W-1:0] key_shift [swsm_pkg::MAX_LEN];
    logic [swsm_pkg::CHAR_W-1:0]  word_buf [swsm_pkg::MAX_LEN];
    logic [swsm_pkg::CHAR_W-1:0]  word_table [swsm_pkg::MAX_WORDS][swsm_pkg::MAX_LEN];
    int                           entry_count;
    answer_t                      pending_answers [$];

    task automatic predict_word_beat(input logic [1:0] op,
                                     input logic [swsm_pkg::POS_W-1:0] pos,
                                     input logic [swsm_pkg::CHAR_W-1:0] ch,
                                     input logic [swsm_pkg::KEY_W-1:0] key);
        int      len;
        int      sum;
        bit      hit;
        bit      same;
        answer_t ans;
        len = (word_length == 0) ? 1 :
              (word_length > swsm_pkg::MAX_LEN) ? swsm_pkg::MAX_LEN : int'(word_length);
        if (op == swsm_pkg::OP_KEY) begin
            key_shift[pos] = swsm_pkg::SHIFT_W'(key % ALPHABET);
            return;
        end
        if (op != swsm_pkg::OP_STORE && op != swsm_pkg::OP_QUERY)
            return;
        if (op == swsm_pkg::OP_STORE) begin
            word_buf[pos] = ch;
        end else begin
            sum = ch + key_shift[pos];
            // bytes below 'a' are not wrapped
            word_buf[pos] = (sum >= LETTER_A + ALPHABET) ?
                            swsm_pkg::CHAR_W'(LETTER_A + (sum - LETTER_A) % ALPHABET) :
                            swsm_pkg::CHAR_W'(sum);
        end
        if (pos != len - 1)
            return;
        ans.kind    = (op == swsm_pkg::OP_QUERY) ? swsm_pkg::KIND_QUERY : swsm_pkg::KIND_STORE;
        ans.matched = 1'b0;
        ans.full    = 1'b0;
        if (op == swsm_pkg::OP_STORE) begin
            if (entry_count >= swsm_pkg::MAX_WORDS) begin
                ans.full = 1'b1;
            end else begin
                for (int j = 0; j < len; j++)
                    word_table[entry_count][j] = word_buf[j];
                entry_count++;
            end
        end else begin
            hit = 1'b0;
            for (int e = 0; e < entry_count && !hit; e++) begin
                same = 1'b1;
                for (int j = 0; j < len; j++)
                    if (word_table[e][j] != word_buf[j])
                        same = 1'b0;
                hit = same;
            end
            ans.matched = hit;
        end
        pending_answers = {pending_answers, ans};
    endtask

    always @(posedge aclk) begin : watch
        answer_t ans;
        if (!aresetn) begin
            word_length = swsm_pkg::WLEN_RESET;
            foreach (key_shift[i])
                key_shift[i] = '0;
            entry_count = 0;
            mismatches  = 0;
            pending_answers.delete();
        end else begin
            if (cfg_wr_en)
                word_length = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result beat, kind %0d tdata %h",
                                 $realtime, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    ans = pending_answers.pop_front();
                    if (m_tuser !== ans.kind || m_tdata !== {6'b0, ans.full, ans.matched}) begin
                        if (mismatches < 10)
                            $display({"%0t: result mismatch, expected kind %0d matched %0d ",
                                      "full %0d, got kind %0d matched %0d full %0d (tdata %h)"},
                                     $realtime, ans.kind, ans.matched, ans.full,
                                     m_tuser, m_tdata[0], m_tdata[1], m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_word_beat(s_tuser, s_tdata[swsm_pkg::POS_W-1:0],
                                  s_tdata[CHAR_LO +: swsm_pkg::CHAR_W],
                                  s_tdata[KEY_LO +: swsm_pkg::KEY_W]);
        end
        outstanding <= pending_answers.size();
    end

endmodule

FILE: bench/shifted_word_set_match_core_test.sv
`timescale 1ns / 100ps
// shifted_word_set_match_core_test: stimulus and verdict for the shifted word set match core;
// drives keys, stored and query words over several word lengths and fills the table.
// depends on swsm_pkg, shifted_word_set_match_core and word_match_checker
module shifted_word_set_match_core_test;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int ALPHABET      = 26;
    localparam int LETTER_A      = 97;
    localparam int SETTLE_CYCLES = swsm_pkg::MAX_WORDS + 40;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [swsm_pkg::WLEN_W-1:0] cfg_wr_data = '0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [1:0]                  s_tuser     = '0;
    logic [31:0]                 s_tdata     = '0;
    logic                        m_tvalid;
    logic                        m_tready    = 1'b0;
    logic [0:0]                  m_tuser;
    logic [7:0]                  m_tdata;
    int                          mismatches;
    int                          outstanding;

    logic            idle_off     = 1'b0;
    int              ready_hold   = 0;
    int              cycle_count  = 0;
    int              cur_len      = swsm_pkg::MAX_LEN;
    int              key_mod [swsm_pkg::MAX_LEN] = '{default: 0};
    int              beats_sent   = 0;
    int              words_stored = 0;
    swsm_pkg::word_t word_pool [$];

    always #5 aclk = ~aclk;

    shifted_word_set_match_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    word_match_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // random result side backpressure in bursts, none while idle_off is set
    always @(posedge aclk) begin
        if (idle_off) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_tready && $urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 4);
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 7);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL shifted_word_set_match_core");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [swsm_pkg::POS_W-1:0] pos,
                             input logic [swsm_pkg::CHAR_W-1:0] ch,
                             input logic [swsm_pkg::KEY_W-1:0] key);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, key, ch, pos};
        do @(posedge aclk); while (!s_tready);
        if (op == swsm_pkg::OP_KEY)
            key_mod[pos] = key % ALPHABET;
        if (op == swsm_pkg::OP_STORE && pos == cur_len - 1)
            words_stored++;
        if (op != OP_NONE)
            beats_sent++;
    endtask

    task automatic set_length(input int value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= swsm_pkg::WLEN_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_len = (value == 0) ? 1 : (value > swsm_pkg::MAX_LEN) ? swsm_pkg::MAX_LEN : value;
    endtask

    function automatic swsm_pkg::word_t letter_word();
        swsm_pkg::word_t w;
        for (int i = 0; i < swsm_pkg::MAX_LEN; i++)
            w[i] = swsm_pkg::CHAR_W'(LETTER_A + $urandom_range(0, ALPHABET - 1));
        return w;
    endfunction

    function automatic swsm_pkg::word_t raw_word();
        swsm_pkg::word_t w;
        for (int i = 0; i < swsm_pkg::MAX_LEN; i++)
            w[i] = swsm_pkg::CHAR_W'($urandom_range(0, 255));
        return w;
    endfunction

    // query characters that shift onto the target under the current keys
    function automatic swsm_pkg::word_t query_for(input swsm_pkg::word_t target);
        swsm_pkg::word_t w;
        for (int i = 0; i < swsm_pkg::MAX_LEN; i++)
            w[i] = swsm_pkg::CHAR_W'(LETTER_A +
                   (int'(target[i]) - LETTER_A - key_mod[i] + ALPHABET) % ALPHABET);
        return w;
    endfunction

    task automatic send_word(input logic [1:0] op, input swsm_pkg::word_t w, input bit cut);
        int stop;
        stop = cut ? int'($urandom_range(0, cur_len - 1)) : cur_len;
        for (int i = 0; i < stop; i++)
            send_beat(op, swsm_pkg::POS_W'(i), w[i], swsm_pkg::KEY_W'($urandom_range(0, 65535)));
    endtask

    task automatic store_one();
        swsm_pkg::word_t w;
        bit              plain;
        bit              cut;
        plain = ($urandom_range(0, 5) != 0);
        cut   = ($urandom_range(0, 7) == 0);
        if (!plain)
            w = raw_word();
        else if (word_pool.size() != 0 && $urandom_range(0, 3) == 0)
            w = word_pool[$urandom_range(0, word_pool.size() - 1)];
        else
            w = letter_word();
        send_word(swsm_pkg::OP_STORE, w, cut);
        if (plain && !cut)
            word_pool = {word_pool, w};
    endtask

    task automatic query_one();
        swsm_pkg::word_t w;
        if (word_pool.size() != 0 && $urandom_range(0, 1) == 0)
            w = query_for(word_pool[$urandom_range(0, word_pool.size() - 1)]);
        else if ($urandom_range(0, 3) == 0)
            w = raw_word();
        else
            w = letter_word();
        send_word(swsm_pkg::OP_QUERY, w, $urandom_range(0, 7) == 0);
    endtask

    task automatic run_phase(input int value, input int budget);
        int stop_at;
        set_length(value);
        idle_off <= ($urandom_range(0, 3) == 0);
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: send_beat(2'($urandom_range(0, 3)),
                             swsm_pkg::POS_W'($urandom_range(0, swsm_pkg::MAX_LEN - 1)),
                             swsm_pkg::CHAR_W'($urandom_range(0, 255)),
                             swsm_pkg::KEY_W'($urandom_range(0, 65535)));
                1: send_beat(swsm_pkg::OP_KEY,
                             swsm_pkg::POS_W'($urandom_range(0, swsm_pkg::MAX_LEN - 1)),
                             swsm_pkg::CHAR_W'($urandom_range(0, 255)),
                             swsm_pkg::KEY_W'($urandom_range(0, 65535)));
                2, 3, 4, 5: store_one();
                default: query_one();
            endcase
        end
    endtask

    initial begin
        swsm_pkg::word_t w;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // lengths only shrink once words are stored, so no stored slot is read past its end
        set_length(31);
        send_beat(OP_NONE, 4'hF, 8'hFF, 16'hFFFF);
        send_beat(swsm_pkg::OP_KEY, 4'd0, 8'hFF, 16'hFFFF);
        send_beat(swsm_pkg::OP_KEY, 4'd7, 8'h00, 16'd25);
        send_beat(swsm_pkg::OP_KEY, 4'd3, 8'h5A, 16'd26);
        send_beat(swsm_pkg::OP_KEY, 4'hF, 8'h00, 16'd0);
        w = letter_word();
        w[0] = 8'h00;
        w[1] = 8'hFF;
        send_word(swsm_pkg::OP_STORE, w, 1'b0);

        run_phase(16, 48);
        run_phase(9, 45);
        run_phase(4, 45);
        run_phase(2, 45);
        run_phase(1, 45);

        // one-character words until the table overflows, no idling
        set_length(0);
        idle_off <= 1'b1;
        while (words_stored < swsm_pkg::MAX_WORDS + 8) begin
            if ($urandom_range(0, 7) == 0)
                query_one();
            else
                store_one();
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS shifted_word_set_match_core");
        else
            $display("FAIL shifted_word_set_match_core");
        $finish;
    end

endmodule
